/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table search package
// Widths, codes, state encoding and the probe request shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

  localparam int DATA_W      = 32;
  localparam int ENTRY_IDX_W = 4;
  localparam int POS_W       = 4;
  localparam int CNT_W       = 5;

  // Search bounds and probe index; wide enough for any entries_in_use value.
  localparam int IDX_W       = 5;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] idx;
  } probe_req_t;

endpackage

/* design/sts_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one write or search word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sts_in_if;
  import sts_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [ENTRY_IDX_W-1:0]   entry_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, action, entry_index, data_value, input ready);
  modport sink (input valid, action, entry_index, data_value, output ready);
endinterface

/* design/sts_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one search result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sts_out_if;
  import sts_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

/* design/sts_mem.sv */
// ----------------------------------------------------------------------------
// Table memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [DW-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued, so a stalled compare keeps its operand.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* design/sts_ctrl.sv */
// ----------------------------------------------------------------------------
// Search controller
// Bisection sequencer: issues one table probe per cycle and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic signed [sts_pkg::DATA_W-1:0] in_key,
  input  logic [sts_pkg::CNT_W-1:0]        count,
  input  logic signed [sts_pkg::DATA_W-1:0] rd_data,
  output sts_pkg::probe_req_t              probe,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [sts_pkg::POS_W-1:0]        out_position
);
  import sts_pkg::*;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt;
  logic [IDX_W-1:0]         end_r, end_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     found_r, found_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;

  logic             accept;
  logic             start;
  logic             out_free;
  logic             out_load;
  logic             hit;
  logic             probe_lt;
  logic [IDX_W-1:0] adv_lo;
  logic [IDX_W-1:0] adv_end;
  logic [IDX_W-1:0] adv_mid;
  logic             adv_open;
  logic [IDX_W-1:0] first_mid;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_action == ACT_SEARCH);
  assign out_free = !out_valid_r || out_ready;

  // The midpoint of an empty range is never read.
  assign first_mid = (count - IDX_W'(1)) >> 1;

  // Compare the probed entry and narrow the range for the next probe.
  assign probe_lt = rd_data < key_r;
  assign hit      = (rd_data == key_r);
  assign adv_lo   = probe_lt ? (mid_r + IDX_W'(1)) : lo_r;
  assign adv_end  = probe_lt ? end_r : mid_r;
  assign adv_open = adv_lo < adv_end;
  assign adv_mid  = adv_lo + ((adv_end - adv_lo - IDX_W'(1)) >> 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (count == '0) ? ST_REPORT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if ((hit || !adv_open) && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    probe.rd_en = 1'b0;
    probe.idx   = mid_r;
    lo_nxt      = lo_r;
    end_nxt     = end_r;
    mid_nxt     = mid_r;
    key_nxt     = key_r;
    out_load    = 1'b0;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt     = in_key;
          lo_nxt      = '0;
          end_nxt     = count;
          mid_nxt     = first_mid;
          probe.rd_en = (count != '0);
          probe.idx   = first_mid;
        end
      end
      ST_PROBE: begin
        if (!hit && adv_open) begin
          lo_nxt      = adv_lo;
          end_nxt     = adv_end;
          mid_nxt     = adv_mid;
          probe.rd_en = 1'b1;
          probe.idx   = adv_mid;
        end else if (out_free) begin
          out_load  = 1'b1;
          found_nxt = hit;
          pos_nxt   = hit ? mid_r[POS_W-1:0] : '0;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_load  = 1'b1;
          found_nxt = 1'b0;
          pos_nxt   = '0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    end_r   <= end_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_position = pos_r;

  `STS_ASSERT_IMP(a_range_open, clk, rst_n, state_r == ST_PROBE, lo_r < end_r, "empty range while probing")
  `STS_ASSERT_IMP(a_mid_in_range, clk, rst_n, state_r == ST_PROBE, (mid_r >= lo_r) && (mid_r < end_r), "probe index outside the search range")
  `STS_ASSERT_NXT(a_read_matches_mid, clk, rst_n, (state_r == ST_PROBE) && probe.rd_en, (state_r == ST_PROBE) && ($past(probe.idx) == mid_r), "compare index differs from the read address")
  `STS_ASSERT_IMP(a_load_when_free, clk, rst_n, out_load, !out_valid_r || out_ready, "result overwrites a word not yet taken")

endmodule

/* design/sorted_table_binary_search_unit.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Table of signed 32-bit entries with write and bisection search words.
// ----------------------------------------------------------------------------
// A write word is stored when it is accepted and gives no result. A search
// word issues its first probe when it is accepted; a search over n entries
// makes at most floor(log2(n)) + 1 probes (five for sixteen), as the table
// memory has a single read port and each probe waits for the previous compare.
// The result then sits in an output register; the next word is taken while it
// waits. The table needs no clearing pass after reset: entries must be written
// before a search reaches them. entries_in_use above TABLE_DEPTH acts as
// TABLE_DEPTH, and a write beyond the table is dropped.
`timescale 1ns / 1ps

module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sts_pkg::CNT_W-1:0]   cfg_wdata,
  sts_in_if.sink                      in_ch,
  sts_out_if.source                   out_ch
);
  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH < 31) ? CNT_W'(TABLE_DEPTH) : CNT_W'(31);

  logic [CNT_W-1:0]         entries_r, entries_nxt;
  logic [CNT_W-1:0]         count;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  probe_req_t               probe;

  assign entries_nxt = cfg_we ? cfg_wdata : entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CNT_RESET;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  assign count = (entries_r > DEPTH_CAP) ? DEPTH_CAP : entries_r;

  assign wr_en = in_ch.valid && in_ch.ready && (in_ch.action == ACT_WRITE)
                 && (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_ch.entry_index);
  assign rd_addr = AW'(probe.idx);

  sts_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_ch.data_value),
    .rd_en     (probe.rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  sts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_action    (in_ch.action),
    .in_key       (in_ch.data_value),
    .count        (count),
    .rd_data      (rd_data),
    .probe        (probe),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_position (out_ch.position)
  );

endmodule
